// ===== rtl/layer_depth_sorter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// layer_depth_sorter_unit_macros.svh
// Assertion shorthands used by the sorter back end (ldsort_back).
// ----------------------------------------------------------------------------
`ifndef LAYER_DEPTH_SORTER_UNIT_MACROS_SVH
`define LAYER_DEPTH_SORTER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define LDS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define LDS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ldsort_pkg.sv =====
// ----------------------------------------------------------------------------
// ldsort_pkg
// Shared constants and types of the layer depth sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package ldsort_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam logic [15:0] POS_LAYER_RESET = 16'd2;

    typedef struct packed {
        logic [15:0] handle;
        logic [15:0] layer;
        logic [15:0] arrival;
        logic [23:0] y;
    } entry_t;

    // one command from front to back
    typedef struct packed {
        logic             store;
        logic             close_list;
        logic [IDX_W-1:0] idx;
        entry_t           entry;
        logic [CNT_W-1:0] count;
        logic             overflow;
        logic [15:0]      special;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ldsort_front.sv =====
// ----------------------------------------------------------------------------
// ldsort_front
// Accepts entries, assigns store slots, tracks drops and closes lists.
// ----------------------------------------------------------------------------
`default_nettype none

module ldsort_front
    import ldsort_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire entry_t      entry,
    input  wire logic        is_last,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    input  wire logic        q_full,
    output logic             cmd_push,
    output cmd_t             cmd
);

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic [15:0]      special_reg;
    logic             room;
    logic [CNT_W-1:0] count_after;
    logic             ovf_after;

    assign cmd_push    = push && !q_full;
    assign room        = fill_reg < CNT_W'(MAX_ENTRIES);
    assign count_after = room ? fill_reg + CNT_W'(1) : fill_reg;
    assign ovf_after   = dropped_reg || !room;

    always_comb
    begin
        cmd.store      = room;
        cmd.close_list = is_last;
        cmd.idx        = fill_reg[IDX_W-1:0];
        cmd.entry      = entry;
        cmd.count      = count_after;
        cmd.overflow   = ovf_after;
        cmd.special    = special_reg;
    end

    always_comb
    begin
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        if (cmd_push)
        begin
            if (is_last)
            begin
                fill_next    = '0;
                dropped_next = 1'b0;
            end
            else
            begin
                fill_next    = count_after;
                dropped_next = ovf_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
            special_reg <= POS_LAYER_RESET;
        end
        else
        begin
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
            if (cfg_we)
            begin
                special_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ldsort_cmdq.sv =====
// ----------------------------------------------------------------------------
// ldsort_cmdq
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ldsort_cmdq
    import ldsort_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_cmd,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_cmd,
    output logic      empty
);

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] cnt_reg;
    logic                  do_wr;
    logic                  do_rd;

    assign full   = cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH);
    assign empty  = cnt_reg == '0;
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = slot_reg[rd_ptr_reg];

    function automatic logic [CMDQ_PTR_W-1:0] ptr_inc(input logic [CMDQ_PTR_W-1:0] p);
        if (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1))
        begin
            return '0;
        end
        return p + CMDQ_PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CMDQ_CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CMDQ_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ldsort_chain.sv =====
// ----------------------------------------------------------------------------
// ldsort_chain
// Sorted insertion chain: one insert or one head removal per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ldsort_chain
    import ldsort_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        ins,
    input  wire entry_t      ins_entry,
    input  wire logic [15:0] special,
    input  wire logic        shift,
    output entry_t           head,
    output logic             head_valid
);

    entry_t cell_reg     [MAX_ENTRIES];
    entry_t cell_next    [MAX_ENTRIES];
    logic   valid_reg    [MAX_ENTRIES];
    logic   valid_next   [MAX_ENTRIES];
    logic   ins_ahead    [MAX_ENTRIES];
    logic   ins_ahead_up [MAX_ENTRIES];

    // strict render order: a drawn before b
    function automatic logic goes_before(input entry_t a, input entry_t b,
                                         input logic [15:0] sp);
        if (a.layer != b.layer)
        begin
            return $signed(a.layer) < $signed(b.layer);
        end
        if (a.layer == sp)
        begin
            return $signed(a.y) > $signed(b.y);
        end
        return a.arrival < b.arrival;
    endfunction

    assign head       = cell_reg[0];
    assign head_valid = valid_reg[0];

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        // empty cells sit after every entry, so the flags run 0..0 1..1
        assign ins_ahead[g] = !valid_reg[g] || goes_before(ins_entry, cell_reg[g], special);

        if (g == 0)
        begin : g_first
            assign ins_ahead_up[g] = 1'b0;
        end
        else
        begin : g_rest
            assign ins_ahead_up[g] = ins_ahead[g-1];
        end

        always_comb
        begin
            cell_next[g]  = cell_reg[g];
            valid_next[g] = valid_reg[g];
            if (shift)
            begin
                if (g < MAX_ENTRIES - 1)
                begin
                    cell_next[g]  = cell_reg[(g + 1) % MAX_ENTRIES];
                    valid_next[g] = valid_reg[(g + 1) % MAX_ENTRIES];
                end
                else
                begin
                    valid_next[g] = 1'b0;
                end
            end
            else if (ins)
            begin
                if (ins_ahead_up[g])
                begin
                    cell_next[g]  = cell_reg[(g + MAX_ENTRIES - 1) % MAX_ENTRIES];
                    valid_next[g] = valid_reg[(g + MAX_ENTRIES - 1) % MAX_ENTRIES];
                end
                else if (ins_ahead[g])
                begin
                    cell_next[g]  = ins_entry;
                    valid_next[g] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[g] <= cell_next[g];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else
            begin
                valid_reg[g] <= valid_next[g];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ldsort_back.sv =====
// ----------------------------------------------------------------------------
// ldsort_back
// Entry store, list load into the sorted chain and result drain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "layer_depth_sorter_unit_macros.svh"

module ldsort_back
    import ldsort_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t cmd,
    input  wire logic cmd_valid,
    output logic      cmd_pop,
    input  wire logic out_pop,
    output logic      out_valid,
    output entry_t    out_entry,
    output logic      out_is_last,
    output logic      out_overflow
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_LOAD  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    entry_t           store_mem [MAX_ENTRIES];
    entry_t           rd_data_reg;
    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] issue_reg;
    logic [CNT_W-1:0] remain_reg;
    logic             ovf_reg;
    logic [15:0]      special_reg;
    logic             rd_pend_reg;
    logic             rd_last_reg;
    logic             issue;
    logic             out_take;
    logic             head_valid;

    // a close waits for an empty chain; stores may overlap the drain
    assign cmd_pop  = cmd_valid && ((state_reg == ST_IDLE) ||
                      ((state_reg == ST_DRAIN) && !cmd.close_list));
    assign issue    = (state_reg == ST_LOAD) && (issue_reg != n_reg);
    assign out_take = out_pop && out_valid;

    assign out_valid    = (state_reg == ST_DRAIN);
    assign out_is_last  = remain_reg == CNT_W'(1);
    assign out_overflow = ovf_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.store)
        begin
            store_mem[cmd.idx] <= cmd.entry;
        end
        if (issue)
        begin
            rd_data_reg <= store_mem[issue_reg[IDX_W-1:0]];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop && cmd.close_list)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (rd_pend_reg && rd_last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_take && out_is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            issue_reg   <= '0;
            remain_reg  <= '0;
            ovf_reg     <= 1'b0;
            special_reg <= POS_LAYER_RESET;
            rd_pend_reg <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= issue;
            rd_last_reg <= issue && (issue_reg == n_reg - CNT_W'(1));
            if ((state_reg == ST_IDLE) && cmd_pop && cmd.close_list)
            begin
                n_reg       <= cmd.count;
                remain_reg  <= cmd.count;
                ovf_reg     <= cmd.overflow;
                special_reg <= cmd.special;
                issue_reg   <= '0;
            end
            else
            begin
                if (issue)
                begin
                    issue_reg <= issue_reg + CNT_W'(1);
                end
                if (out_take)
                begin
                    remain_reg <= remain_reg - CNT_W'(1);
                end
            end
        end
    end

    ldsort_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ins        (rd_pend_reg),
        .ins_entry  (rd_data_reg),
        .special    (special_reg),
        .shift      (out_take),
        .head       (out_entry),
        .head_valid (head_valid)
    );

    `LDS_ASSERT_IMP(a_close_in_idle, cmd_pop && cmd.close_list, state_reg == ST_IDLE, "close taken while busy")
    `LDS_ASSERT_IMP(a_no_cmd_in_load, state_reg == ST_LOAD, !cmd_pop, "command taken during load")
    `LDS_ASSERT_IMP(a_head_present, state_reg == ST_DRAIN, head_valid, "drain with empty chain head")
    `LDS_ASSERT_NXT(a_remain_dec, out_take && !out_is_last, remain_reg == $past(remain_reg) - CNT_W'(1), "result count slipped")

endmodule

`default_nettype wire

// ===== rtl/layer_depth_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// layer_depth_sorter_unit
// Stable render-order sorter for lists of drawable entries.
//
//   channel   direction  handshake        fields
//   entry     in         push / full      entry_handle..entry_is_last
//   result    out        empty / pop      out_handle..out_overflow
//   config    in         cfg_we           position_sorted_layer
//
// Entries are taken one per cycle into a two-deep command queue and written
// to the entry store. Closing a list of n entries loads it with one store
// read per cycle into the sorted insertion chain; the n results then leave
// at one per pop. Stores of the next list overlap the drain. Reset clears
// list counters, queue and chain valid bits; the store needs no clearing.
// The entry side stalls only when the command queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_depth_sorter_unit
    import ldsort_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic        [15:0] entry_handle,
    input  wire logic signed [15:0] entry_layer,
    input  wire logic        [15:0] entry_arrival,
    input  wire logic signed [23:0] entry_y,
    input  wire logic               entry_is_last,
    output logic                    empty,
    input  wire logic               pop,
    output logic             [15:0] out_handle,
    output logic signed      [15:0] out_layer,
    output logic             [15:0] out_arrival,
    output logic signed      [23:0] out_y,
    output logic                    out_is_last,
    output logic                    out_overflow,
    input  wire logic               cfg_we,
    input  wire logic signed [15:0] position_sorted_layer
);

    entry_t in_entry;
    entry_t res_entry;
    cmd_t   push_cmd;
    cmd_t   head_cmd;
    logic   cmd_push;
    logic   cmd_pop;
    logic   q_empty;
    logic   res_valid;

    always_comb
    begin
        in_entry.handle  = entry_handle;
        in_entry.layer   = entry_layer;
        in_entry.arrival = entry_arrival;
        in_entry.y       = entry_y;
    end

    ldsort_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .entry    (in_entry),
        .is_last  (entry_is_last),
        .cfg_we   (cfg_we),
        .cfg_data (position_sorted_layer),
        .q_full   (full),
        .cmd_push (cmd_push),
        .cmd      (push_cmd)
    );

    ldsort_cmdq u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (push_cmd),
        .full   (full),
        .rd_en  (cmd_pop),
        .rd_cmd (head_cmd),
        .empty  (q_empty)
    );

    ldsort_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (head_cmd),
        .cmd_valid    (!q_empty),
        .cmd_pop      (cmd_pop),
        .out_pop      (pop),
        .out_valid    (res_valid),
        .out_entry    (res_entry),
        .out_is_last  (out_is_last),
        .out_overflow (out_overflow)
    );

    assign empty       = !res_valid;
    assign out_handle  = res_entry.handle;
    assign out_layer   = res_entry.layer;
    assign out_arrival = res_entry.arrival;
    assign out_y       = res_entry.y;

endmodule

`default_nettype wire
